// ----- rtl/core/gto_pkg.sv -----
`default_nettype none

package gto_pkg;

    // Field widths of the stream words
    localparam int VERTEX_W    = 4;
    localparam int WEIGHT_W    = 15;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 8;

    // Weight that stands for a missing edge
    localparam logic [WEIGHT_W-1:0] NO_EDGE_INF = 15'd32767;

    // Input word kinds carried on tuser
    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_TRAVERSE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_VERTEX_COUNT = 1'b0;
    localparam logic CFG_ORDER_MODE   = 1'b1;

    // Traversal order
    localparam logic MODE_BFS = 1'b0;
    localparam logic MODE_DFS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_WR,
        ST_BAD,
        ST_FETCH,
        ST_VREAD,
        ST_ROW,
        ST_FINISH
    } state_t;

    // Request from the sequencer to the output stage
    typedef struct packed {
        logic                push;
        logic                flush;
        logic                bad;
        logic [VERTEX_W-1:0] vertex;
    } emit_t;

    // What the output stage can take this cycle
    typedef struct packed {
        logic slot_free;
        logic push_ok;
    } out_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gto_adj_store.sv -----
`default_nettype none

module gto_adj_store #(
    parameter int NV = 16,
    parameter int IW = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [NV-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [NV-1:0] wr_data
);

    logic [NV-1:0] mem [NV];
    logic [NV-1:0] row_valid_reg;
    logic [NV-1:0] rd_data_reg;

    // Mark rows written since reset; an unwritten row reads as no edges
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Write one row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gto_work_list.sv -----
`default_nettype none

module gto_work_list #(
    parameter int NV = 16,
    parameter int IW = 4
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [IW-1:0] rd_addr,
    output logic      [IW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [IW-1:0] wr_addr,
    input  wire logic [IW-1:0] wr_data
);

    logic [IW-1:0] mem [NV];
    logic [IW-1:0] rd_data_reg;

    // Write one queue or stack entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gto_out_stage.sv -----
`default_nettype none

module gto_out_stage (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire gto_pkg::emit_t               emit,
    output gto_pkg::out_stat_t                stat,
    output logic                              tvalid,
    input  wire logic                         tready,
    output logic [gto_pkg::VERTEX_W-1:0]      vertex,
    output logic                              tlast,
    output logic                              tuser
);

    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic [gto_pkg::VERTEX_W-1:0]   pend_vertex_reg;
    logic [gto_pkg::VERTEX_W-1:0]   pend_vertex_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [gto_pkg::VERTEX_W-1:0]   out_vertex_reg;
    logic [gto_pkg::VERTEX_W-1:0]   out_vertex_next;
    logic                           out_last_reg;
    logic                           out_last_next;
    logic                           out_bad_reg;
    logic                           out_bad_next;
    logic                           slot_free;
    logic                           push_ok;

    // The newest vertex waits in the pending slot until it is known
    // whether another vertex follows it
    assign slot_free = !out_valid_reg || tready;
    assign push_ok   = !pend_valid_reg || slot_free;

    always_comb
    begin
        pend_valid_next  = pend_valid_reg;
        pend_vertex_next = pend_vertex_reg;
        out_valid_next   = out_valid_reg && !tready;
        out_vertex_next  = out_vertex_reg;
        out_last_next    = out_last_reg;
        out_bad_next     = out_bad_reg;

        if (emit.push && push_ok)
        begin
            // Retire the pending vertex as a middle word
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_vertex_next = pend_vertex_reg;
                out_last_next   = 1'b0;
                out_bad_next    = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_vertex_next = emit.vertex;
        end
        else if (emit.flush && slot_free)
        begin
            // Retire the pending vertex as the final word
            out_valid_next  = 1'b1;
            out_vertex_next = pend_vertex_reg;
            out_last_next   = 1'b1;
            out_bad_next    = 1'b0;
            pend_valid_next = 1'b0;
        end
        else if (emit.bad && slot_free)
        begin
            out_valid_next  = 1'b1;
            out_vertex_next = '0;
            out_last_next   = 1'b1;
            out_bad_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_vertex_reg <= pend_vertex_next;
        out_vertex_reg  <= out_vertex_next;
        out_last_reg    <= out_last_next;
        out_bad_reg     <= out_bad_next;
    end

    assign stat.slot_free = slot_free;
    assign stat.push_ok   = push_ok;
    assign tvalid         = out_valid_reg;
    assign vertex         = out_vertex_reg;
    assign tlast          = out_last_reg;
    assign tuser          = out_bad_reg;

endmodule

`default_nettype wire

// ----- rtl/core/graph_traversal_order_core.sv -----
`default_nettype none

// Graph traversal core. A load word (tuser 0) writes one entry of the
// adjacency matrix; a weight of 0 or 32767 removes the edge, any other
// weight sets it, and rows or columns beyond the stored matrix are dropped.
// A load reads one matrix row and writes it back. A traverse
// word (tuser 1) clears the visited marks and streams out every vertex
// below vertex_count reachable from the start vertex, breadth first or
// depth first as order_mode selects, with neighbors taken in ascending
// index order and tlast on the final vertex. A start vertex not below
// vertex_count gives a single word with vertex 0, tlast and tuser set.
// Each vertex taken off the work list passes through a work list read,
// then an adjacency row read (both synchronous memories in series),
// before its neighbors appear; in breadth-first order the neighbors
// found are emitted from that one row read, in depth-first order each
// descent or backtrack step goes through both reads again.
// Input is accepted only between commands; the output register lets the
// block take the next command while the last result is still waiting.
module graph_traversal_order_core #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // from_vertex[3:0], to_vertex[7:4], edge_weight[22:8],
    // start_vertex[26:23], zero[31:27]
    input  wire logic [gto_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd[0]
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // visited_vertex[3:0], zero[7:4]
    output logic [gto_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    output logic                                     m_axis_tlast,
    // bad_start[0]
    output logic                                     m_axis_tuser,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [gto_pkg::COUNT_W-1:0]         cfg_data
);

    localparam int NV = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int IW = $clog2(NV);
    localparam int PW = $clog2(NV + 1);
    localparam int CW = gto_pkg::COUNT_W;
    localparam int VW = gto_pkg::VERTEX_W;

    // Input word fields
    logic                           cmd;
    logic [VW-1:0]                  from_vertex;
    logic [VW-1:0]                  to_vertex;
    logic [gto_pkg::WEIGHT_W-1:0]   edge_weight;
    logic [VW-1:0]                  start_vertex;

    assign cmd          = s_axis_tuser;
    assign from_vertex  = s_axis_tdata[3:0];
    assign to_vertex    = s_axis_tdata[7:4];
    assign edge_weight  = s_axis_tdata[22:8];
    assign start_vertex = s_axis_tdata[26:23];

    // Configuration
    logic [CW-1:0] vertex_count_reg;
    logic          order_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= CW'(16);
            order_mode_reg   <= gto_pkg::MODE_BFS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gto_pkg::CFG_VERTEX_COUNT: vertex_count_reg <= cfg_data;
                gto_pkg::CFG_ORDER_MODE:   order_mode_reg   <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Effective vertex count and the columns it allows
    logic [CW-1:0] n_eff;
    logic [NV-1:0] col_mask;

    assign n_eff = (vertex_count_reg > CW'(NV)) ? CW'(NV) : vertex_count_reg;

    always_comb
    begin
        for (int j = 0; j < NV; j++)
        begin
            col_mask[j] = (CW'(j) < n_eff);
        end
    end

    // Memory ports
    logic          adj_rd_en;
    logic [IW-1:0] adj_rd_addr;
    logic [NV-1:0] adj_rd_data;
    logic          adj_wr_en;
    logic [IW-1:0] adj_wr_addr;
    logic [NV-1:0] adj_wr_data;
    logic          wl_rd_en;
    logic [IW-1:0] wl_rd_addr;
    logic [IW-1:0] wl_rd_data;
    logic          wl_wr_en;
    logic [IW-1:0] wl_wr_addr;
    logic [IW-1:0] wl_wr_data;

    gto_adj_store #(
        .NV (NV),
        .IW (IW)
    ) u_adj_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (adj_rd_en),
        .rd_addr (adj_rd_addr),
        .rd_data (adj_rd_data),
        .wr_en   (adj_wr_en),
        .wr_addr (adj_wr_addr),
        .wr_data (adj_wr_data)
    );

    gto_work_list #(
        .NV (NV),
        .IW (IW)
    ) u_work_list (
        .clk     (clk),
        .rd_en   (wl_rd_en),
        .rd_addr (wl_rd_addr),
        .rd_data (wl_rd_data),
        .wr_en   (wl_wr_en),
        .wr_addr (wl_wr_addr),
        .wr_data (wl_wr_data)
    );

    // Output stage
    gto_pkg::emit_t     emit;
    gto_pkg::out_stat_t out_stat;
    logic [VW-1:0]      out_vertex;

    gto_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .emit   (emit),
        .stat   (out_stat),
        .tvalid (m_axis_tvalid),
        .tready (m_axis_tready),
        .vertex (out_vertex),
        .tlast  (m_axis_tlast),
        .tuser  (m_axis_tuser)
    );

    assign m_axis_tdata = gto_pkg::OUT_TDATA_W'(out_vertex);

    // Sequencer state
    gto_pkg::state_t state_reg;
    gto_pkg::state_t state_next;
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   tail_next;
    logic [PW-1:0]   tail_m1;
    logic [NV-1:0]   visited_reg;
    logic [NV-1:0]   visited_next;
    logic [IW-1:0]   ld_row_reg;
    logic [IW-1:0]   ld_row_next;
    logic [IW-1:0]   ld_col_reg;
    logic [IW-1:0]   ld_col_next;
    logic            ld_set_reg;
    logic            ld_set_next;
    logic            ld_en_reg;
    logic            ld_en_next;

    // Unvisited neighbors of the row just read, lowest first
    logic [NV-1:0] cand;
    logic          cand_any;
    logic [IW-1:0] low_idx;
    logic [NV-1:0] low_bit;
    logic [NV-1:0] ld_bit;
    logic          edge_present;
    logic          load_in_range;
    logic          start_bad;

    assign cand     = adj_rd_data & ~visited_reg & col_mask;
    assign cand_any = |cand;
    assign low_bit  = NV'(1) << low_idx;
    assign ld_bit   = NV'(1) << ld_col_reg;
    assign tail_m1  = tail_reg - PW'(1);

    always_comb
    begin
        low_idx = '0;
        for (int k = NV - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                low_idx = IW'(k);
            end
        end
    end

    assign edge_present  = (edge_weight != '0) && (edge_weight != gto_pkg::NO_EDGE_INF);
    assign load_in_range = (CW'(from_vertex) < CW'(NV)) && (CW'(to_vertex) < CW'(NV));
    assign start_bad     = (CW'(start_vertex) >= n_eff);

    // Next state and memory commands
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        visited_next  = visited_reg;
        ld_row_next   = ld_row_reg;
        ld_col_next   = ld_col_reg;
        ld_set_next   = ld_set_reg;
        ld_en_next    = ld_en_reg;
        s_axis_tready = 1'b0;
        adj_rd_en     = 1'b0;
        adj_rd_addr   = wl_rd_data;
        adj_wr_en     = 1'b0;
        adj_wr_addr   = ld_row_reg;
        adj_wr_data   = ld_set_reg ? (adj_rd_data | ld_bit) : (adj_rd_data & ~ld_bit);
        wl_rd_en      = 1'b0;
        wl_rd_addr    = head_reg[IW-1:0];
        wl_wr_en      = 1'b0;
        wl_wr_addr    = tail_reg[IW-1:0];
        wl_wr_data    = low_idx;
        emit          = '0;
        emit.vertex   = VW'(low_idx);

        unique case (state_reg)
            gto_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (cmd == gto_pkg::CMD_LOAD)
                    begin
                        // Read the row, patch one bit next cycle
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = from_vertex[IW-1:0];
                        ld_row_next = from_vertex[IW-1:0];
                        ld_col_next = to_vertex[IW-1:0];
                        ld_set_next = edge_present;
                        ld_en_next  = load_in_range;
                        state_next  = gto_pkg::ST_LOAD_WR;
                    end
                    else if (start_bad)
                    begin
                        visited_next = '0;
                        state_next   = gto_pkg::ST_BAD;
                    end
                    else
                    begin
                        // Visit the start vertex and seed the work list
                        visited_next = NV'(1) << start_vertex[IW-1:0];
                        emit.push    = 1'b1;
                        emit.vertex  = start_vertex;
                        wl_wr_en     = 1'b1;
                        wl_wr_addr   = '0;
                        wl_wr_data   = start_vertex[IW-1:0];
                        head_next    = '0;
                        tail_next    = PW'(1);
                        state_next   = gto_pkg::ST_FETCH;
                    end
                end
            end

            gto_pkg::ST_LOAD_WR:
            begin
                adj_wr_en  = ld_en_reg;
                state_next = gto_pkg::ST_IDLE;
            end

            gto_pkg::ST_BAD:
            begin
                emit.bad = 1'b1;
                if (out_stat.slot_free)
                begin
                    state_next = gto_pkg::ST_IDLE;
                end
            end

            gto_pkg::ST_FETCH:
            begin
                // Take the next vertex off the queue or the stack top
                if (order_mode_reg == gto_pkg::MODE_DFS)
                begin
                    if (tail_reg == '0)
                    begin
                        state_next = gto_pkg::ST_FINISH;
                    end
                    else
                    begin
                        wl_rd_en   = 1'b1;
                        wl_rd_addr = tail_m1[IW-1:0];
                        state_next = gto_pkg::ST_VREAD;
                    end
                end
                else
                begin
                    if (head_reg == tail_reg)
                    begin
                        state_next = gto_pkg::ST_FINISH;
                    end
                    else
                    begin
                        wl_rd_en   = 1'b1;
                        head_next  = head_reg + PW'(1);
                        state_next = gto_pkg::ST_VREAD;
                    end
                end
            end

            gto_pkg::ST_VREAD:
            begin
                adj_rd_en  = 1'b1;
                state_next = gto_pkg::ST_ROW;
            end

            gto_pkg::ST_ROW:
            begin
                if (cand_any)
                begin
                    // Visit the lowest unvisited neighbor when the output can take it
                    emit.push = 1'b1;
                    if (out_stat.push_ok)
                    begin
                        visited_next = visited_reg | low_bit;
                        wl_wr_en     = 1'b1;
                        tail_next    = tail_reg + PW'(1);
                        if (order_mode_reg == gto_pkg::MODE_DFS)
                        begin
                            state_next = gto_pkg::ST_FETCH;
                        end
                    end
                end
                else
                begin
                    // Row exhausted: backtrack in depth-first order
                    if (order_mode_reg == gto_pkg::MODE_DFS)
                    begin
                        tail_next = tail_m1;
                    end
                    state_next = gto_pkg::ST_FETCH;
                end
            end

            gto_pkg::ST_FINISH:
            begin
                emit.flush = 1'b1;
                if (out_stat.slot_free)
                begin
                    state_next = gto_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = gto_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gto_pkg::ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            visited_reg <= '0;
            ld_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            visited_reg <= visited_next;
            ld_en_reg   <= ld_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_row_reg <= ld_row_next;
        ld_col_reg <= ld_col_next;
        ld_set_reg <= ld_set_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/gto_checker.sv -----
`default_nettype none

module gto_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [gto_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input wire logic                                m_axis_tlast,
    input wire logic                                m_axis_tuser
);

    // A bad-start word always closes its traversal
    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("bad-start word without tlast");

    // A bad-start word carries vertex zero
    a_bad_vertex_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad-start word with nonzero vertex");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // A command keeps the input closed for at least the next cycle
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened right after a command");

endmodule

bind graph_traversal_order_core gto_checker u_gto_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 340;
    localparam int NV            = 16;

    // One expected output word
    typedef struct packed {
        logic [gto_pkg::VERTEX_W-1:0] vertex;
        logic                         last;
        logic                         bad;
    } visit_t;

    // Mirror of the traversal core: matrix, visited marks and registers
    class traversal_scoreboard;
        logic [NV-1:0]                adj_rows [NV];
        logic [NV-1:0]                visited;
        logic [gto_pkg::COUNT_W-1:0]  vertex_count;
        logic                         order_mode;
        logic [gto_pkg::VERTEX_W-1:0] trail [$];
        visit_t                       visits_due [$];
        int                           failures;

        function new();
            foreach (adj_rows[i])
                adj_rows[i] = '0;
            visited      = '0;
            vertex_count = gto_pkg::COUNT_W'(16);
            order_mode   = gto_pkg::MODE_BFS;
            failures     = 0;
        endfunction

        function void write_reg(logic index, logic [gto_pkg::COUNT_W-1:0] value);
            if (index == gto_pkg::CFG_VERTEX_COUNT)
                vertex_count = value;
            else
                order_mode = value[0];
        endfunction

        function int pending();
            return visits_due.size();
        endfunction

        function void visit(int v);
            visited[v] = 1'b1;
            trail.insert(trail.size(), gto_pkg::VERTEX_W'(v));
        endfunction

        // FIFO work list, neighbors in ascending order
        function void walk_breadth(int start, int n);
            int fifo [NV];
            int head;
            int tail;
            int v;
            head = 0;
            tail = 0;
            visit(start);
            fifo[tail] = start;
            tail++;
            while (head < tail)
            begin
                v = fifo[head];
                head++;
                for (int j = 0; j < n; j++)
                begin
                    if (adj_rows[v][j] && !visited[j] && tail < n)
                    begin
                        visit(j);
                        fifo[tail] = j;
                        tail++;
                    end
                end
            end
        endfunction

        // Stack work list with a resume column per level
        function void walk_depth(int start, int n);
            int stack_v [NV];
            int resume [NV];
            int depth;
            int v;
            int j;
            visit(start);
            stack_v[0] = start;
            resume[0]  = 0;
            depth      = 1;
            while (depth > 0)
            begin
                v = stack_v[depth-1];
                j = resume[depth-1];
                while (j < n && !(adj_rows[v][j] && !visited[j]))
                    j++;
                if (j < n && depth < n)
                begin
                    resume[depth-1] = j + 1;
                    visit(j);
                    stack_v[depth] = j;
                    resume[depth]  = 0;
                    depth++;
                end
                else
                    depth--;
            end
        endfunction

        // Apply one accepted input word and queue the words it causes
        function void note_word(logic cmd, logic [gto_pkg::IN_TDATA_W-1:0] data);
            logic [gto_pkg::VERTEX_W-1:0] row;
            logic [gto_pkg::VERTEX_W-1:0] col;
            logic [gto_pkg::VERTEX_W-1:0] start;
            logic [gto_pkg::WEIGHT_W-1:0] weight;
            int                           n;
            row    = data[3:0];
            col    = data[7:4];
            weight = data[22:8];
            start  = data[26:23];
            n      = (vertex_count > NV) ? NV : int'(vertex_count);
            if (cmd == gto_pkg::CMD_LOAD)
                adj_rows[row][col] = (weight != '0) && (weight != gto_pkg::NO_EDGE_INF);
            else
            begin
                visited = '0;
                if (start >= n)
                    visits_due.insert(visits_due.size(),
                                      '{vertex: '0, last: 1'b1, bad: 1'b1});
                else
                begin
                    trail.delete();
                    if (order_mode == gto_pkg::MODE_DFS)
                        walk_depth(start, n);
                    else
                        walk_breadth(start, n);
                    foreach (trail[i])
                        visits_due.insert(visits_due.size(),
                                          '{vertex: trail[i],
                                            last: (i == trail.size() - 1),
                                            bad: 1'b0});
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            failures++;
        endtask

        // Compare one output word with the oldest expectation
        task check_word(logic [gto_pkg::VERTEX_W-1:0] vertex, logic last, logic bad);
            visit_t want;
            if (visits_due.size() == 0)
                report($sformatf("unexpected word: vertex %0d last %0b bad_start %0b",
                                 vertex, last, bad));
            else
            begin
                want = visits_due.pop_front();
                if (vertex !== want.vertex)
                    report($sformatf("visited_vertex %0d, expected %0d",
                                     vertex, want.vertex));
                if (last !== want.last)
                    report($sformatf("tlast %0b, expected %0b (vertex %0d)",
                                     last, want.last, want.vertex));
                if (bad !== want.bad)
                    report($sformatf("bad_start %0b, expected %0b (vertex %0d)",
                                     bad, want.bad, want.vertex));
            end
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [gto_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [gto_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            m_axis_tuser;
    logic                            cfg_we;
    logic                            cfg_index;
    logic [gto_pkg::COUNT_W-1:0]     cfg_data;

    traversal_scoreboard sb;
    bit                  quiet;
    bit                  hold_req;
    int                  cycle_count;
    int                  random_sent;

    graph_traversal_order_core #(
        .MAX_VERTICES(16)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: cycle limit hit, %0d words outstanding", sb.pending());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every word the block hands over
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata[gto_pkg::VERTEX_W-1:0], m_axis_tlast,
                          m_axis_tuser);
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial
    begin : receiver
        int held;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(negedge clk);
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= 24);
        end
    end

    // Offer one word, hold it until taken; returns at a falling edge
    task automatic send_word(logic cmd, logic [gto_pkg::IN_TDATA_W-1:0] data);
        while (!quiet && $urandom_range(99) < 24)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        forever
        begin
            @(posedge clk);
            if (s_axis_tready)
                break;
        end
        sb.note_word(cmd, data);
        @(negedge clk);
    endtask

    task automatic load_edge(int row, int col, int weight);
        send_word(gto_pkg::CMD_LOAD,
                  {5'b0, 4'($urandom_range(15)), 15'(weight), 4'(col), 4'(row)});
    endtask

    task automatic traverse(int start);
        send_word(gto_pkg::CMD_TRAVERSE, {5'b0, 4'(start), 15'($urandom_range(32767)),
                                          4'($urandom_range(15)), 4'($urandom_range(15))});
    endtask

    // Drop valid and wait until the block has gone idle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(logic index, int value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= gto_pkg::COUNT_W'(value);
        sb.write_reg(index, gto_pkg::COUNT_W'(value));
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly vertices inside the active range, some anywhere
    function automatic int pick_vertex(int n, int pct_inside);
        if (n > 0 && $urandom_range(99) < pct_inside)
            return $urandom_range(n - 1);
        return $urandom_range(15);
    endfunction

    function automatic int pick_weight();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return 0;
        if (roll < 20)
            return gto_pkg::NO_EDGE_INF;
        if (roll < 30)
            return $urandom_range(32767);
        return $urandom_range(32766, 1);
    endfunction

    // One setting, then a random mix of edge loads and traversals
    task automatic random_phase(int count, logic mode, int words);
        int n;
        drain();
        cfg_write(gto_pkg::CFG_VERTEX_COUNT, count);
        cfg_write(gto_pkg::CFG_ORDER_MODE, mode);
        n = (count > NV) ? NV : count;
        for (int k = 0; k < words; k++)
        begin
            if ($urandom_range(99) < 60)
                load_edge(pick_vertex(n, 90), pick_vertex(n, 90), pick_weight());
            else
                traverse(pick_vertex(n, 85));
            random_sent++;
        end
    endtask

    initial
    begin : stimulus
        int phase_counts [15];
        int p;
        int words;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = gto_pkg::CMD_LOAD;
        cfg_we        = 1'b0;
        cfg_index     = gto_pkg::CFG_VERTEX_COUNT;
        cfg_data      = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        cycle_count   = 0;
        random_sent   = 0;
        phase_counts  = '{16, 16, 16, 8, 2, 1, 12, 16, 5, 31, 3, 0, 16, 9, 16};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Small graph at reset settings: weight extremes, removal, self loops
        load_edge(0, 1, 1);
        load_edge(0, 2, 32766);
        load_edge(1, 3, 16384);
        load_edge(2, 3, 5);
        load_edge(3, 15, 7);
        load_edge(15, 0, gto_pkg::NO_EDGE_INF);
        load_edge(15, 15, 100);
        load_edge(2, 14, 9);
        load_edge(2, 14, 0);
        traverse(0);
        traverse(15);
        traverse(7);

        // Same graph, depth first
        drain();
        cfg_write(gto_pkg::CFG_ORDER_MODE, gto_pkg::MODE_DFS);
        traverse(0);
        traverse(3);

        // Narrow range: bad starts, edge to column 15 not scanned
        drain();
        cfg_write(gto_pkg::CFG_VERTEX_COUNT, 4);
        traverse(4);
        traverse(15);
        traverse(0);

        // Zero count makes every start bad
        drain();
        cfg_write(gto_pkg::CFG_VERTEX_COUNT, 0);
        traverse(0);

        // Oversized count is limited to the matrix size
        drain();
        cfg_write(gto_pkg::CFG_VERTEX_COUNT, 31);
        cfg_write(gto_pkg::CFG_ORDER_MODE, gto_pkg::MODE_BFS);
        traverse(2);

        drain();
        cfg_write(gto_pkg::CFG_VERTEX_COUNT, 1);
        traverse(0);

        // Random phases; phase 1 carries the long output hold-off,
        // phase 2 runs without any idling
        p = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            words = $urandom_range(32, 20);
            quiet = (p == 2);
            if (p == 1)
            begin
                drain();
                hold_req = 1'b1;
            end
            random_phase(phase_counts[p % 15], logic'(p % 2), words);
            p++;
        end

        drain();
        quiet = 1'b0;
        if (sb.failures == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
